[hdl/bwc_pkg.sv]
// ----------------------------------------------------------------------------
// bwc_pkg
// Shared types, constants and a helper function for the BMP window crop block.
// ----------------------------------------------------------------------------
package bwc_pkg;

    // Largest accepted source dimension in pixels or rows.
    localparam int C_MAX_DIM         = 4096;
    localparam int C_BYTES_PER_PIXEL = 3;
    localparam int C_ROW_ALIGN       = 4;
    localparam int C_BITS_PER_PIXEL  = 24;

    // Field and counter widths.
    localparam int C_BYTE_W   = 8;
    localparam int C_DIM_W    = 13;
    localparam int C_POS_W    = 12;
    localparam int C_CFG_IDX_W = 3;
    localparam int C_COL_W    = 14;   // byte position within a row
    localparam int C_ROW_W    = 12;   // stored row index
    localparam int C_STOP_W   = 16;   // window end byte position, before validation
    localparam int C_PAD_W    = 2;

    localparam logic [C_BYTE_W-1:0] C_PAD_BYTE = 8'h00;

    // Configuration register indexes.
    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_WINDOW_X      = 3'd2,
        CFG_WINDOW_Y      = 3'd3,
        CFG_WINDOW_W      = 3'd4,
        CFG_WINDOW_H      = 3'd5
    } t_cfg_idx;

    // Raw configuration registers.
    typedef struct packed {
        logic [C_DIM_W-1:0] source_width;
        logic [C_DIM_W-1:0] source_height;
        logic [C_POS_W-1:0] window_x;
        logic [C_POS_W-1:0] window_y;
        logic [C_DIM_W-1:0] window_w;
        logic [C_DIM_W-1:0] window_h;
    } t_cfg_raw;

    // Values derived from the configuration, held in registers.
    typedef struct packed {
        logic                src_ok;        // source size is usable
        logic                win_ok;        // window lies inside the source
        logic [C_COL_W-1:0]  first_byte;    // first window byte within a row
        logic [C_STOP_W-1:0] last_byte;     // last window byte within a row
        logic [C_POS_W-1:0]  first_row;
        logic [C_COL_W-1:0]  last_row;
        logic [C_PAD_W-1:0]  win_pad;       // zero bytes after each window row
        logic [C_COL_W-1:0]  src_row_last;  // last byte index of a source row
        logic [C_ROW_W-1:0]  src_last_row;  // last stored row index
    } t_cfg_drv;

    // Results caused by one input transaction.
    typedef struct packed {
        logic                valid;
        logic                err;
        logic [C_BYTE_W-1:0] data;
        logic                last;
        logic [C_PAD_W-1:0]  pad;
        logic                pad_last;
    } t_result;

    localparam t_cfg_raw C_CFG_RESET = '{
        source_width:  13'd1,
        source_height: 13'd1,
        window_x:      12'd0,
        window_y:      12'd0,
        window_w:      13'd1,
        window_h:      13'd1
    };

    // Derive the compare values used per byte. Padding is (4 - 3*n mod 4) mod 4,
    // which reduces to n mod 4.
    function automatic t_cfg_drv f_derive(input t_cfg_raw c);
        t_cfg_drv             d;
        logic [C_COL_W-1:0]   x_end;
        logic [C_COL_W-1:0]   y_end;
        logic [C_STOP_W-1:0]  row_bytes;
        x_end = C_COL_W'(c.window_x) + C_COL_W'(c.window_w);
        y_end = C_COL_W'(c.window_y) + C_COL_W'(c.window_h);
        d.src_ok = (c.source_width != '0) && (c.source_height != '0) &&
                   (32'(c.source_width) <= C_MAX_DIM) &&
                   (32'(c.source_height) <= C_MAX_DIM);
        d.win_ok = d.src_ok && (c.window_w != '0) && (c.window_h != '0) &&
                   (x_end <= C_COL_W'(c.source_width)) &&
                   (y_end <= C_COL_W'(c.source_height));
        d.first_byte = C_COL_W'(c.window_x) * C_COL_W'(C_BYTES_PER_PIXEL);
        d.last_byte  = C_STOP_W'(x_end) * C_STOP_W'(C_BYTES_PER_PIXEL) - C_STOP_W'(1);
        d.first_row  = c.window_y;
        d.last_row   = y_end - C_COL_W'(1);
        d.win_pad    = c.window_w[C_PAD_W-1:0];
        row_bytes    = C_STOP_W'(c.source_width) * C_STOP_W'(C_BYTES_PER_PIXEL)
                       + C_STOP_W'(c.source_width[C_PAD_W-1:0]);
        d.src_row_last = C_COL_W'(row_bytes - C_STOP_W'(1));
        d.src_last_row = C_ROW_W'(c.source_height - C_DIM_W'(1));
        return d;
    endfunction

endpackage

[hdl/bwc_cfg.sv]
// ----------------------------------------------------------------------------
// bwc_cfg
// Configuration registers and the registered compare values derived from them.
// ----------------------------------------------------------------------------
module bwc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bwc_pkg::C_CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bwc_pkg::C_DIM_W-1:0]         i_cfg_data,
    output bwc_pkg::t_cfg_drv                   o_drv
);

    bwc_pkg::t_cfg_raw r_raw;
    bwc_pkg::t_cfg_raw n_raw;
    bwc_pkg::t_cfg_drv r_drv;

    // Register write decode; unknown indexes change nothing.
    always_comb begin
        n_raw = r_raw;
        case (i_cfg_index)
            bwc_pkg::CFG_SOURCE_WIDTH:  n_raw.source_width  = i_cfg_data;
            bwc_pkg::CFG_SOURCE_HEIGHT: n_raw.source_height = i_cfg_data;
            bwc_pkg::CFG_WINDOW_X:      n_raw.window_x      = i_cfg_data[bwc_pkg::C_POS_W-1:0];
            bwc_pkg::CFG_WINDOW_Y:      n_raw.window_y      = i_cfg_data[bwc_pkg::C_POS_W-1:0];
            bwc_pkg::CFG_WINDOW_W:      n_raw.window_w      = i_cfg_data;
            bwc_pkg::CFG_WINDOW_H:      n_raw.window_h      = i_cfg_data;
            default: ;
        endcase
    end

    // Derived values are computed from the new contents so they are ready at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= bwc_pkg::C_CFG_RESET;
            r_drv <= bwc_pkg::f_derive(bwc_pkg::C_CFG_RESET);
        end else if (i_cfg_we) begin
            r_raw <= n_raw;
            r_drv <= bwc_pkg::f_derive(n_raw);
        end
    end

    assign o_drv = r_drv;

endmodule

[hdl/bwc_track.sv]
// ----------------------------------------------------------------------------
// bwc_track
// Byte and row counters of the source frame and the per-byte crop decision.
// ----------------------------------------------------------------------------
module bwc_track (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_new_frame,
    input  logic                             i_accept,
    input  logic [bwc_pkg::C_BYTE_W-1:0]     i_pixel_byte,
    input  bwc_pkg::t_cfg_drv                i_drv,
    output bwc_pkg::t_result                 o_result
);

    logic [bwc_pkg::C_COL_W-1:0] r_byte_in_row;
    logic [bwc_pkg::C_COL_W-1:0] n_byte_in_row;
    logic [bwc_pkg::C_ROW_W-1:0] r_row_index;
    logic [bwc_pkg::C_ROW_W-1:0] n_row_index;
    logic                        r_error_sent;
    logic                        n_error_sent;
    logic                        r_crop_done;
    logic                        n_crop_done;

    logic in_rows;
    logic in_cols;
    logic row_end;
    logic last_row;
    logic frame_wrap;

    // Position of the current byte against the window.
    assign in_rows  = (r_row_index >= i_drv.first_row) &&
                      (bwc_pkg::C_COL_W'(r_row_index) <= i_drv.last_row);
    assign in_cols  = (r_byte_in_row >= i_drv.first_byte) &&
                      (bwc_pkg::C_STOP_W'(r_byte_in_row) <= i_drv.last_byte);
    assign row_end  = (bwc_pkg::C_STOP_W'(r_byte_in_row) == i_drv.last_byte);
    assign last_row = (bwc_pkg::C_COL_W'(r_row_index) == i_drv.last_row);

    // Results for this byte and the flag updates.
    always_comb begin
        o_result     = '0;
        n_error_sent = r_error_sent;
        n_crop_done  = r_crop_done;
        if (!r_error_sent && !i_drv.win_ok) begin
            o_result.valid = 1'b1;
            o_result.err   = 1'b1;
            n_error_sent   = 1'b1;
        end else if (!r_error_sent && !r_crop_done && in_rows && in_cols) begin
            o_result.valid    = 1'b1;
            o_result.data     = i_pixel_byte;
            o_result.pad      = row_end ? i_drv.win_pad : '0;
            o_result.last     = row_end && last_row && (i_drv.win_pad == '0);
            o_result.pad_last = last_row;
            if (row_end && last_row) begin
                n_crop_done = 1'b1;
            end
        end
        // The end of the frame clears both flags for the next frame.
        if (frame_wrap) begin
            n_error_sent = 1'b0;
            n_crop_done  = 1'b0;
        end
    end

    // Counter advance; the end of the last source row starts a new frame.
    always_comb begin
        n_byte_in_row = r_byte_in_row;
        n_row_index   = r_row_index;
        frame_wrap    = 1'b0;
        if (i_drv.src_ok) begin
            if (r_byte_in_row == i_drv.src_row_last) begin
                n_byte_in_row = '0;
                if (r_row_index == i_drv.src_last_row) begin
                    n_row_index = '0;
                    frame_wrap  = 1'b1;
                end else begin
                    n_row_index = r_row_index + bwc_pkg::C_ROW_W'(1);
                end
            end else begin
                n_byte_in_row = r_byte_in_row + bwc_pkg::C_COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_new_frame) begin
            r_byte_in_row <= '0;
            r_row_index   <= '0;
            r_error_sent  <= 1'b0;
            r_crop_done   <= 1'b0;
        end else if (i_accept) begin
            r_byte_in_row <= n_byte_in_row;
            r_row_index   <= n_row_index;
            r_error_sent  <= n_error_sent;
            r_crop_done   <= n_crop_done;
        end
    end

endmodule

[hdl/bwc_emit.sv]
// ----------------------------------------------------------------------------
// bwc_emit
// Result register: sends the window byte, then any zero padding bytes.
// ----------------------------------------------------------------------------
module bwc_emit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  bwc_pkg::t_result                 i_result,
    output logic                             o_free,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bwc_pkg::C_BYTE_W-1:0]     o_out_byte,
    output logic                             o_is_last,
    output logic                             o_window_error
);

    logic                         r_valid;
    logic [bwc_pkg::C_BYTE_W-1:0] r_byte;
    logic                         r_last;
    logic                         r_err;
    logic [bwc_pkg::C_PAD_W-1:0]  r_pad_left;
    logic                         r_pad_last;
    logic                         take;

    assign take   = r_valid && i_out_ready;
    assign o_free = !r_valid || (i_out_ready && (r_pad_left == '0));

    // Control part of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pad_left <= '0;
        end else if (take && (r_pad_left != '0)) begin
            r_pad_left <= r_pad_left - bwc_pkg::C_PAD_W'(1);
        end else if (i_load) begin
            r_valid    <= 1'b1;
            r_pad_left <= i_result.pad;
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload part; a padding transaction replaces the byte with zero.
    always_ff @(posedge i_clk) begin
        if (take && (r_pad_left != '0)) begin
            r_byte <= bwc_pkg::C_PAD_BYTE;
            r_last <= r_pad_last && (r_pad_left == bwc_pkg::C_PAD_W'(1));
            r_err  <= 1'b0;
        end else if (i_load) begin
            r_byte     <= i_result.data;
            r_last     <= i_result.last;
            r_err      <= i_result.err;
            r_pad_last <= i_result.pad_last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_byte;
    assign o_is_last      = r_last;
    assign o_window_error = r_err;

    // An error result is a lone transaction without the last flag.
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err) |-> (!r_last && (r_pad_left == '0)))
        else $error("error result carries last flag or padding");

    // Pending padding keeps the result register busy and blocks new input.
    a_pad_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad_left != '0) |-> (r_valid && !o_free))
        else $error("padding pending while input is open");

    // A transaction taken with padding pending is followed by a zero byte.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (r_pad_left != '0)) |=> (r_valid && (r_byte == bwc_pkg::C_PAD_BYTE)))
        else $error("padding byte is not zero");

endmodule

[hdl/bmp_window_crop.sv]
// ----------------------------------------------------------------------------
// bmp_window_crop
// Crops a pixel window out of the stored byte stream of a 24-bit BMP image and
// pads every output row to a multiple of four bytes.
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_ready      i_pixel_byte
//   output    out        o_out_valid / i_out_ready    o_out_byte, o_is_last,
//                                                     o_window_error
//   config    in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// One input byte is taken per cycle while the result register is free; its
// result is registered and shown in the next cycle. The last window byte of
// a row holds the input while the result register sends its 0 to 3 pad bytes.
// Reset is synchronous and active low; it restores the register defaults and
// starts a new frame, as does every configuration write.
// A stalled output only blocks input once the result register is occupied.
// ----------------------------------------------------------------------------
module bmp_window_crop (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bwc_pkg::C_BYTE_W-1:0]     i_pixel_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bwc_pkg::C_BYTE_W-1:0]     o_out_byte,
    output logic                             o_is_last,
    output logic                             o_window_error,
    input  logic                             i_cfg_we,
    input  logic [bwc_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bwc_pkg::C_DIM_W-1:0]      i_cfg_data
);

    bwc_pkg::t_cfg_drv drv;
    bwc_pkg::t_result  result;
    logic              free;
    logic              accept;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    // Configuration registers.
    bwc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_drv       (drv)
    );

    // Frame position and crop decision.
    bwc_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_new_frame  (i_cfg_we),
        .i_accept     (accept),
        .i_pixel_byte (i_pixel_byte),
        .i_drv        (drv),
        .o_result     (result)
    );

    // Result register with padding insertion.
    bwc_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && result.valid),
        .i_result       (result),
        .o_free         (free),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_is_last      (o_is_last),
        .o_window_error (o_window_error)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bmp_window_crop. A class predicts the cropped and
// padded byte stream for every accepted source byte and checks each output
// transaction in order. Directed cases cover the reset settings, window and
// source errors, frame wrap and spare register indexes. Random settings follow,
// with bursty input and a patterned output stall, then the largest settings.
// ----------------------------------------------------------------------------

// One expected output transaction.
typedef struct packed {
    logic [bwc_pkg::C_BYTE_W-1:0] data;
    logic                         last;
    logic                         err;
} t_crop_byte;

// Tracks the crop state and holds the output bytes still due.
class crop_ledger;
    bit [bwc_pkg::C_DIM_W-1:0] src_width, src_height, win_width, win_height;
    bit [bwc_pkg::C_POS_W-1:0] win_col, win_row;
    bit [bwc_pkg::C_COL_W-1:0] col_byte;
    bit [bwc_pkg::C_ROW_W-1:0] row_num;
    bit                        error_out, crop_over;
    t_crop_byte                due_bytes[$];
    int                        mismatches, bytes_taken, bytes_productive;
    int                        results_checked, errors_seen;

    function new();
        src_width  = 1;
        src_height = 1;
        win_col    = 0;
        win_row    = 0;
        win_width  = 1;
        win_height = 1;
        start_frame();
    endfunction

    function void start_frame();
        col_byte  = '0;
        row_num   = '0;
        error_out = 1'b0;
        crop_over = 1'b0;
    endfunction

    // Zero bytes needed to bring a row of this many pixels to the alignment.
    function int unsigned row_pad(int unsigned px);
        return (bwc_pkg::C_ROW_ALIGN - (px * bwc_pkg::C_BYTES_PER_PIXEL) %
                bwc_pkg::C_ROW_ALIGN) % bwc_pkg::C_ROW_ALIGN;
    endfunction

    function bit source_usable();
        int unsigned w, h;
        w = src_width;
        h = src_height;
        return w != 0 && h != 0 && w <= bwc_pkg::C_MAX_DIM && h <= bwc_pkg::C_MAX_DIM;
    endfunction

    function bit window_fits();
        int unsigned x, y, w, h;
        x = win_col;
        y = win_row;
        w = win_width;
        h = win_height;
        return source_usable() && w != 0 && h != 0 &&
               x + w <= src_width && y + h <= src_height;
    endfunction

    function int pending();
        return due_bytes.size();
    endfunction

    function void due(logic [bwc_pkg::C_BYTE_W-1:0] data, logic last, logic err);
        t_crop_byte item;
        item.data = data;
        item.last = last;
        item.err  = err;
        due_bytes.push_back(item);
    endfunction

    // Any write starts a new frame; a spare index changes no register.
    function void write_reg(logic [bwc_pkg::C_CFG_IDX_W-1:0] idx,
                            logic [bwc_pkg::C_DIM_W-1:0] value);
        case (idx)
            bwc_pkg::CFG_SOURCE_WIDTH:  src_width  = value;
            bwc_pkg::CFG_SOURCE_HEIGHT: src_height = value;
            bwc_pkg::CFG_WINDOW_X:      win_col    = value[bwc_pkg::C_POS_W-1:0];
            bwc_pkg::CFG_WINDOW_Y:      win_row    = value[bwc_pkg::C_POS_W-1:0];
            bwc_pkg::CFG_WINDOW_W:      win_width  = value;
            bwc_pkg::CFG_WINDOW_H:      win_height = value;
            default: ;
        endcase
        start_frame();
    endfunction

    task report(string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Work out the output bytes caused by one accepted source byte.
    task take_source_byte(logic [bwc_pkg::C_BYTE_W-1:0] b);
        int unsigned x, y, w, h, first_b, stop_b, pad, row_len, col, row;
        bit          row_end, final_row;
        int          size_in;
        size_in = due_bytes.size();
        x   = win_col;
        y   = win_row;
        w   = win_width;
        h   = win_height;
        col = col_byte;
        row = row_num;
        bytes_taken++;

        if (!error_out && !window_fits()) begin
            due('0, 1'b0, 1'b1);
            error_out = 1'b1;
            errors_seen++;
        end else if (!error_out && !crop_over && row >= y && row < y + h) begin
            first_b = x * bwc_pkg::C_BYTES_PER_PIXEL;
            stop_b  = (x + w) * bwc_pkg::C_BYTES_PER_PIXEL;
            if (col >= first_b && col < stop_b) begin
                row_end   = (col == stop_b - 1);
                final_row = (row == y + h - 1);
                pad       = row_end ? row_pad(w) : 0;
                due(b, row_end && final_row && pad == 0, 1'b0);
                for (int unsigned i = 0; i < pad; i++)
                    due(bwc_pkg::C_PAD_BYTE, final_row && i == pad - 1, 1'b0);
                if (row_end && final_row)
                    crop_over = 1'b1;
            end
        end

        // The position counters only move while the source size is usable.
        if (source_usable()) begin
            row_len = src_width * bwc_pkg::C_BYTES_PER_PIXEL + row_pad(src_width);
            col++;
            if (col >= row_len) begin
                row++;
                if (row >= src_height) begin
                    start_frame();
                end else begin
                    col_byte = '0;
                    row_num  = bwc_pkg::C_ROW_W'(row);
                end
            end else begin
                col_byte = bwc_pkg::C_COL_W'(col);
            end
        end
        if (due_bytes.size() > size_in)
            bytes_productive++;
    endtask

    // Compare one output transaction with the oldest byte due.
    task check_crop_byte(logic [bwc_pkg::C_BYTE_W-1:0] data, logic last, logic err);
        t_crop_byte want;
        results_checked++;
        if (due_bytes.size() == 0) begin
            report($sformatf("output %02h last %0b error %0b with nothing due",
                             data, last, err));
            return;
        end
        want = due_bytes.pop_front();
        if (data !== want.data)
            report($sformatf("out_byte %02h, expected %02h", data, want.data));
        if (last !== want.last)
            report($sformatf("is_last %0b, expected %0b", last, want.last));
        if (err !== want.err)
            report($sformatf("window_error %0b, expected %0b", err, want.err));
    endtask
endclass

module tb;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int COUNTED_ITEMS = 200;
    localparam logic [bwc_pkg::C_CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [bwc_pkg::C_CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_BURSTY} t_ready_mode;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [bwc_pkg::C_BYTE_W-1:0]     i_pixel_byte;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic [bwc_pkg::C_BYTE_W-1:0]     o_out_byte;
    logic                             o_is_last;
    logic                             o_window_error;
    logic                             i_cfg_we;
    logic [bwc_pkg::C_CFG_IDX_W-1:0]  i_cfg_index;
    logic [bwc_pkg::C_DIM_W-1:0]      i_cfg_data;

    crop_ledger  ledger;
    int          cycle_count = 0;
    int          burst_left;
    int          settings_used;
    t_ready_mode ready_mode = RDY_ALWAYS;

    bmp_window_crop dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_byte   (i_pixel_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_is_last      (o_is_last),
        .o_window_error (o_window_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Both channels are sampled here, input before output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready === 1'b1)
                ledger.take_source_byte(i_pixel_byte);
            if (o_out_valid === 1'b1 && i_out_ready)
                ledger.check_crop_byte(o_out_byte, o_is_last, o_window_error);
        end
    end

    // The receiver switches between four stall patterns at random.
    always @(negedge i_clk) begin
        if (cycle_count % 64 == 0)
            ready_mode = t_ready_mode'($urandom_range(0, 3));
        case (ready_mode)
            RDY_ALWAYS:   i_out_ready = 1'b1;
            RDY_RANDOM:   i_out_ready = ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: i_out_ready = (cycle_count % 5 != 0);
            default:      i_out_ready = (cycle_count % 16 < 4);
        endcase
    end

    // Watchdog.
    initial begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge i_clk);
        $display("timeout after %0d cycles, %0d bytes still due",
                 cycle_count, ledger.pending());
        $display("tb failed");
        $finish;
    end

    // Offer one source byte and wait for its transaction. Bursts of random
    // length are sometimes separated by random gaps.
    task push_byte(logic [bwc_pkg::C_BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 16);
        end
        i_pixel_byte = b;
        i_in_valid   = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0)
            i_in_valid = 1'b0;
    endtask

    // Stop sending until every byte due has come out.
    task hold_until_drained();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (ledger.pending() != 0)
            @(negedge i_clk);
    endtask

    task settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task write_reg(logic [bwc_pkg::C_CFG_IDX_W-1:0] idx,
                   logic [bwc_pkg::C_DIM_W-1:0] value);
        i_cfg_index = idx;
        i_cfg_data  = value;
        i_cfg_we    = 1'b1;
        @(posedge i_clk);
        ledger.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task apply_setting(int sw, int sh, int wx, int wy, int ww, int wh);
        settle();
        write_reg(bwc_pkg::CFG_SOURCE_WIDTH,  bwc_pkg::C_DIM_W'(sw));
        write_reg(bwc_pkg::CFG_SOURCE_HEIGHT, bwc_pkg::C_DIM_W'(sh));
        write_reg(bwc_pkg::CFG_WINDOW_X,      bwc_pkg::C_DIM_W'(wx));
        write_reg(bwc_pkg::CFG_WINDOW_Y,      bwc_pkg::C_DIM_W'(wy));
        write_reg(bwc_pkg::CFG_WINDOW_W,      bwc_pkg::C_DIM_W'(ww));
        write_reg(bwc_pkg::CFG_WINDOW_H,      bwc_pkg::C_DIM_W'(wh));
        settings_used++;
    endtask

    // Random source bytes, optionally pausing once until drained.
    task send_bytes(int n, int pause_at);
        for (int i = 0; i < n; i++) begin
            if (i == pause_at)
                hold_until_drained();
            push_byte(bwc_pkg::C_BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task run_directed();
        // Reset settings: a one-pixel source cropped whole, then the row's pad byte and the start of the next frame.
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hA5);
        hold_until_drained();
        push_byte(8'h5A);
        push_byte(8'h80);
        push_byte(8'h01);
        // Empty window width: an error on the first byte of each frame.
        apply_setting(1, 1, 0, 0, 0, 1);
        send_bytes(5, -1);
        // Source wider than the limit: one error, then silence.
        apply_setting(bwc_pkg::C_MAX_DIM + 1, 1, 0, 0, 1, 1);
        send_bytes(2, -1);
        // Zero source height.
        apply_setting(1, 0, 0, 0, 1, 1);
        send_bytes(1, -1);
        // Window past the right edge, past the bottom, and of zero height.
        apply_setting(4, 2, 2, 0, 3, 1);
        send_bytes(1, -1);
        apply_setting(4, 2, 0, 1, 1, 2);
        send_bytes(1, -1);
        apply_setting(2, 2, 0, 0, 1, 0);
        send_bytes(1, -1);
        // A write to a spare index in mid-frame restarts the frame.
        apply_setting(1, 2, 0, 1, 1, 1);
        send_bytes(3, -1);
        settle();
        write_reg(CFG_SPARE_HI, 13'h1FFF);
        send_bytes(8, -1);
    endtask

    task run_random();
        int base, kind, sw, sh, wx, wy, ww, wh, n, pause_at, remaining;
        base = ledger.bytes_taken;
        while (ledger.bytes_taken - base < COUNTED_ITEMS) begin
            kind = $urandom_range(0, 99);
            sw = $urandom_range(1, 9);
            sh = $urandom_range(1, 5);
            ww = $urandom_range(1, sw);
            wx = $urandom_range(0, sw - ww);
            wh = $urandom_range(1, sh);
            wy = $urandom_range(0, sh - wh);
            if (kind < 12) begin
                // Window that does not fit.
                case ($urandom_range(0, 3))
                    0:       ww = sw - wx + $urandom_range(1, 3);
                    1:       wh = sh - wy + $urandom_range(1, 3);
                    2:       ww = 0;
                    default: wh = 0;
                endcase
            end else if (kind < 18) begin
                // Unusable source size.
                if ($urandom_range(0, 1))
                    sw = $urandom_range(0, 1) ? 0
                                              : $urandom_range(bwc_pkg::C_MAX_DIM + 1, 8191);
                else
                    sh = $urandom_range(0, 1) ? 0
                                              : $urandom_range(bwc_pkg::C_MAX_DIM + 1, 8191);
            end else if (kind < 22) begin
                // Raw register values over the full write width.
                sw = $urandom_range(0, 8191);
                sh = $urandom_range(0, 8191);
                wx = $urandom_range(0, 8191);
                wy = $urandom_range(0, 8191);
                ww = $urandom_range(0, 8191);
                wh = $urandom_range(0, 8191);
            end else if ($urandom_range(0, 3) == 0) begin
                // The top data bit of the position registers is dropped.
                wx += bwc_pkg::C_MAX_DIM;
                wy += bwc_pkg::C_MAX_DIM;
            end
            apply_setting(sw, sh, wx, wy, ww, wh);
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          bwc_pkg::C_DIM_W'($urandom_range(0, 8191)));

            if (kind >= 12 && kind < 22) begin
                n = $urandom_range(1, 8);
            end else begin
                n = ((sw * 3 + 3) / 4) * 4 * sh * $urandom_range(1, 2);
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, n);
            end
            // Keep the whole run near its planned number of source bytes.
            remaining = COUNTED_ITEMS - (ledger.bytes_taken - base);
            if (n > remaining)
                n = remaining;
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
            send_bytes(n, pause_at);
        end
    endtask

    // Largest positions and sizes the block takes, over the first bytes of a frame.
    task run_extremes();
        apply_setting(bwc_pkg::C_MAX_DIM, bwc_pkg::C_MAX_DIM,
                      bwc_pkg::C_MAX_DIM - 1, bwc_pkg::C_MAX_DIM - 1, 1, 1);
        send_bytes(6, -1);
        apply_setting(bwc_pkg::C_MAX_DIM, bwc_pkg::C_MAX_DIM, 0, 0,
                      bwc_pkg::C_MAX_DIM, bwc_pkg::C_MAX_DIM);
        send_bytes(8, -1);
        // One pixel too wide and one row too tall at the limit.
        apply_setting(bwc_pkg::C_MAX_DIM, bwc_pkg::C_MAX_DIM,
                      bwc_pkg::C_MAX_DIM - 1, 0, 2, 1);
        send_bytes(2, -1);
        apply_setting(bwc_pkg::C_MAX_DIM, bwc_pkg::C_MAX_DIM,
                      0, bwc_pkg::C_MAX_DIM - 1, 1, 2);
        send_bytes(2, -1);
    endtask

    initial begin
        ledger        = new();
        burst_left    = 0;
        settings_used = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_pixel_byte  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = bwc_pkg::CFG_SOURCE_WIDTH;
        i_cfg_data    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random();
        run_extremes();
        settle();
        if (ledger.pending() != 0)
            ledger.report($sformatf("%0d bytes never came out", ledger.pending()));

        $display("Run: %0d source bytes (%0d with output), %0d output transactions, %0d settings, %0d errors.",
                 ledger.bytes_taken, ledger.bytes_productive, ledger.results_checked,
                 settings_used, ledger.errors_seen);
        $display("Window and source errors, frame wrap, spare writes and limit settings.");
        if (ledger.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
